// ----- rtl/assert_macros.svh -----
// Assertion macros used by the executor (vrtwc_exec).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ----- rtl/vrtwc_pkg.sv -----
package vrtwc_pkg;

  localparam int unsigned DataW = 64;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_READ = 2'd1,
    OP_MAP  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_WRITTEN = 3'd0,
    KIND_MAPPED  = 3'd1,
    KIND_NOFREE  = 3'd2,
    KIND_READ    = 3'd3,
    KIND_BADSIZE = 3'd4
  } kind_t;

  localparam logic [63:0] ValidBit = 64'h800;
  localparam logic [63:0] PageLow  = 64'hFFF;
  localparam logic [63:0] TypeMask = 64'hFF;
  localparam logic [7:0]  TypeWc   = 8'd1;
  localparam logic [5:0]  MinAddrBits = 6'd36;
  localparam logic [5:0]  MaxAddrBits = 6'd52;
  localparam int unsigned MaxResults = 10;

  // One command word handed from the front end to the executor.
  typedef struct packed {
    op_t          op;
    logic [2:0]   idx;
    logic [63:0]  base;
    logic [63:0]  mask;
    logic [51:0]  addr;
    logic [52:0]  size;
  } cmd_t;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  idx;
    logic [63:0] base;
    logic [63:0] mask;
    logic        last;
  } res_t;

endpackage

// ----- rtl/vrtwc_front.sv -----
module vrtwc_front #(
  parameter int unsigned QDEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  vrtwc_pkg::cmd_t     cmd_in,
  output logic                cmd_valid,
  input  logic                cmd_take,
  output vrtwc_pkg::cmd_t     cmd_out
);

  localparam int unsigned AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  vrtwc_pkg::cmd_t q_r [QDEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          wr, rd;

  // Opcode 3 words produce nothing and are dropped here.
  assign full      = (cnt_r == (AW+1)'(QDEPTH));
  assign wr        = push && !full && (cmd_in.op != vrtwc_pkg::OP_NONE);
  assign cmd_valid = (cnt_r != '0);
  assign rd        = cmd_valid && cmd_take;
  assign cmd_out   = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wp_r] <= cmd_in;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= (wp_r == AW'(QDEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (rd) begin
        rp_r <= (rp_r == AW'(QDEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

endmodule

// ----- rtl/vrtwc_exec.sv -----
`include "assert_macros.svh"
module vrtwc_exec #(
  parameter int unsigned ENTRIES = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [5:0]      phys_addr_bits,
  input  logic [3:0]      entries_in_use,
  input  logic            cmd_valid,
  output logic            cmd_take,
  input  vrtwc_pkg::cmd_t cmd,
  output logic            res_valid,
  input  logic            res_ready,
  output vrtwc_pkg::res_t res
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_CLEAR, S_PRE, S_POST, S_FREE, S_CHUNK, S_FINAL, S_EMIT
  } state_t;

  state_t      state_r, ret_r;
  logic [63:0] base_r [ENTRIES];
  logic [63:0] mask_r [ENTRIES];
  logic [63:0] pm_r;
  logic [CW-1:0] n_r, i_r;
  logic [63:0] sz_r, fb_r, fe_r;
  logic [63:0] ob_r, oe_r;
  logic [7:0]  ot_r;
  logic [63:0] cb_r, crem_r, csz_r;
  logic [3:0]  nres_r;
  logic [IW-1:0] k_r;
  vrtwc_pkg::res_t res_r;
  logic        res_valid_r;
  logic [5:0]  w;
  logic [IW-1:0] ii;
  logic [IW-1:0] cidx;
  logic [63:0] eb, es, ee, cp;
  logic        ev;
  logic        res_load;

  assign res_valid = res_valid_r;
  assign res       = res_r;
  assign cmd_take  = (state_r == S_IDLE) && !res_valid_r;
  assign ii        = i_r[IW-1:0];
  assign cidx      = IW'(cmd.idx);

  // The map states that write the result register this cycle.
  assign res_load  = (state_r == S_CLEAR || state_r == S_CHUNK || state_r == S_FINAL ||
                      state_r == S_EMIT) && (!res_valid_r || res_ready);

  always_comb begin
    w = phys_addr_bits;
    if (w < vrtwc_pkg::MinAddrBits) w = vrtwc_pkg::MinAddrBits;
    if (w > vrtwc_pkg::MaxAddrBits) w = vrtwc_pkg::MaxAddrBits;
  end

  // Decode of the entry under the scan pointer.
  always_comb begin
    ev = mask_r[ii][11];
    eb = base_r[ii] & pm_r & ~vrtwc_pkg::PageLow;
    es = (~(mask_r[ii] & pm_r & ~vrtwc_pkg::PageLow) & pm_r) + 64'd1;
    ee = eb + es;
  end

  // Largest power of two not above the remaining size; the lowest set bit
  // of the base caps it.
  always_comb begin
    cp = 64'd0;
    for (int b = 0; b < 64; b++) begin
      if (crem_r[b]) cp = 64'd1 << b;
    end
    if (cb_r != 0 && ((cb_r & (cp - 64'd1)) != 0)) cp = cb_r & (~cb_r + 64'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r <= S_IDLE;
      res_valid_r <= 1'b0;
      i_r <= '0;
      n_r <= '0;
      for (int e = 0; e < ENTRIES; e++) mask_r[e] <= '0;
    end else begin
      if (res_valid_r && res_ready && !res_load) res_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cmd_valid && !res_valid_r) begin
            pm_r <= (64'd1 << w) - 64'd1;
            n_r <= (32'(entries_in_use) > ENTRIES) ? CW'(ENTRIES) : CW'(entries_in_use);
            nres_r <= '0;
            i_r <= '0;
            sz_r <= 64'd1;
            case (cmd.op)
              vrtwc_pkg::OP_LOAD: begin
                if (32'(cmd.idx) < ENTRIES) begin
                  base_r[cidx] <= cmd.base;
                  mask_r[cidx] <= cmd.mask;
                end
                res_r <= '{vrtwc_pkg::KIND_WRITTEN, cmd.idx, cmd.base, cmd.mask, 1'b1};
                res_valid_r <= 1'b1;
              end
              vrtwc_pkg::OP_READ: begin
                if (32'(cmd.idx) < ENTRIES) begin
                  res_r <= '{vrtwc_pkg::KIND_READ, cmd.idx, base_r[cidx], mask_r[cidx], 1'b1};
                end else begin
                  res_r <= '{vrtwc_pkg::KIND_READ, cmd.idx, 64'd0, 64'd0, 1'b1};
                end
                res_valid_r <= 1'b1;
              end
              vrtwc_pkg::OP_MAP: begin
                if (cmd.size == '0) begin
                  res_r <= '{vrtwc_pkg::KIND_BADSIZE, 3'd0, 64'd0, 64'd0, 1'b1};
                  res_valid_r <= 1'b1;
                end else begin
                  fb_r <= {12'd0, cmd.addr};
                  crem_r <= {11'd0, cmd.size};
                  fe_r <= 64'd0;
                  ob_r <= 64'd0;
                  state_r <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          // First pass rounds the size up, one doubling a cycle.
          if (sz_r < crem_r) begin
            sz_r <= sz_r << 1;
          end else if (fe_r == 64'd0 && i_r == '0 && ob_r != 64'd1) begin
            fb_r <= fb_r & ~(sz_r - 64'd1);
            fe_r <= (fb_r & ~(sz_r - 64'd1)) + sz_r;
            ob_r <= 64'd1;
          end else if (i_r == n_r) begin
            i_r <= '0;
            state_r <= S_FREE;
            ret_r <= S_FINAL;
          end else if (ev && fb_r < ee && fe_r > eb) begin
            ob_r <= eb;
            oe_r <= ee;
            ot_r <= base_r[ii][7:0];
            state_r <= S_CLEAR;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        S_CLEAR: begin
          if (!res_valid_r || res_ready) begin
            mask_r[ii] <= '0;
            res_r <= '{vrtwc_pkg::KIND_WRITTEN, 3'(ii), base_r[ii], 64'd0, 1'b0};
            res_valid_r <= (nres_r < 4'(vrtwc_pkg::MaxResults - 1));
            nres_r <= nres_r + 1'b1;
            cb_r <= ob_r;
            crem_r <= (fb_r > ob_r) ? fb_r - ob_r : 64'd0;
            state_r <= S_PRE;
          end
        end
        S_PRE, S_POST: begin
          if (crem_r == 64'd0) begin
            if (state_r == S_PRE) begin
              cb_r <= fe_r;
              crem_r <= (oe_r > fe_r) ? oe_r - fe_r : 64'd0;
              state_r <= S_POST;
            end else begin
              i_r <= '0;
              state_r <= S_FREE;
              ret_r <= S_FINAL;
            end
          end else begin
            csz_r <= cp;
            i_r <= '0;
            ret_r <= state_r;
            state_r <= S_FREE;
          end
        end
        S_FREE: begin
          if (i_r == n_r) begin
            if (ret_r == S_FINAL) begin
              state_r <= S_EMIT;
            end else begin
              crem_r <= 64'd0;
              state_r <= ret_r;
            end
          end else if (!mask_r[ii][11]) begin
            k_r <= ii;
            state_r <= (ret_r == S_FINAL) ? S_FINAL : S_CHUNK;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        S_CHUNK: begin
          if (!res_valid_r || res_ready) begin
            base_r[k_r] <= (cb_r & pm_r & ~vrtwc_pkg::PageLow) | {56'd0, ot_r};
            mask_r[k_r] <= (~(csz_r - 64'd1) & pm_r) | vrtwc_pkg::ValidBit;
            res_r <= '{vrtwc_pkg::KIND_WRITTEN, 3'(k_r),
                       (cb_r & pm_r & ~vrtwc_pkg::PageLow) | {56'd0, ot_r},
                       (~(csz_r - 64'd1) & pm_r) | vrtwc_pkg::ValidBit, 1'b0};
            res_valid_r <= (nres_r < 4'(vrtwc_pkg::MaxResults - 1));
            if (nres_r != 4'd15) nres_r <= nres_r + 1'b1;
            cb_r <= cb_r + csz_r;
            crem_r <= crem_r - csz_r;
            state_r <= ret_r;
          end
        end
        S_FINAL: begin
          if (!res_valid_r || res_ready) begin
            base_r[k_r] <= (fb_r & pm_r & ~vrtwc_pkg::PageLow) | {56'd0, vrtwc_pkg::TypeWc};
            mask_r[k_r] <= (~(sz_r - 64'd1) & pm_r) | vrtwc_pkg::ValidBit;
            res_r <= '{vrtwc_pkg::KIND_WRITTEN, 3'(k_r),
                       (fb_r & pm_r & ~vrtwc_pkg::PageLow) | {56'd0, vrtwc_pkg::TypeWc},
                       (~(sz_r - 64'd1) & pm_r) | vrtwc_pkg::ValidBit, 1'b0};
            res_valid_r <= (nres_r < 4'(vrtwc_pkg::MaxResults - 1));
            nres_r <= nres_r + 1'b1;
            ret_r <= S_IDLE;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!res_valid_r || res_ready) begin
            if (ret_r == S_IDLE) begin
              res_r <= '{vrtwc_pkg::KIND_MAPPED, 3'(k_r), base_r[k_r], mask_r[k_r], 1'b1};
            end else begin
              res_r <= '{vrtwc_pkg::KIND_NOFREE, 3'd0, 64'd0, 64'd0, 1'b1};
            end
            res_valid_r <= 1'b1;
            fe_r <= 64'd0;
            ob_r <= 64'd0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEVER(a_take_busy, clk, rst_n, cmd_take && state_r != S_IDLE, "take while busy")
  `ASSERT_CLK(a_res_hold, clk, rst_n, res_valid_r && !res_ready |=> res_valid_r, "result lost")
  `ASSERT_NEVER(a_cnt_range, clk, rst_n, i_r > n_r, "scan past count")

endmodule

// ----- rtl/variable_range_table_wc_mapper.sv -----
// Range table with write-combining mapper. A load or read word is answered on
// the result ports from the result register loaded at the edge on which the
// executor takes it, and the executor takes the next command only after that
// result has been popped. A map with a bad size is answered the same way;
// other maps run through the executor's one-step-per-cycle loops: one
// doubling per step while the size is rounded up (up to 53), one per entry in
// the overlap scan and in every free-entry search, and one per entry word
// written, which output stalls can hold. A two-deep command queue sits
// between input and executor; results leave through one register.
module variable_range_table_wc_mapper #(
  parameter int unsigned ENTRIES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_wdata,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_opcode,
  input  logic [2:0]  in_entry_index,
  input  logic [63:0] in_base_word,
  input  logic [63:0] in_mask_word,
  input  logic [51:0] in_region_addr,
  input  logic [52:0] in_region_size,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_kind,
  output logic [2:0]  out_out_index,
  output logic [63:0] out_out_base,
  output logic [63:0] out_out_mask,
  output logic        out_last
);

  logic [5:0] pab_r;
  logic [3:0] eiu_r;
  vrtwc_pkg::cmd_t cin, cq;
  vrtwc_pkg::res_t rs;
  logic cv, ct, rv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pab_r <= 6'd36;
      eiu_r <= 4'd8;
    end else if (cfg_we) begin
      if (cfg_index) eiu_r <= cfg_wdata[3:0];
      else pab_r <= cfg_wdata;
    end
  end

  assign cin = '{vrtwc_pkg::op_t'(in_opcode), in_entry_index, in_base_word,
                 in_mask_word, in_region_addr, in_region_size};

  vrtwc_front u_front (.clk, .rst_n, .push(in_push), .full(in_full), .cmd_in(cin),
    .cmd_valid(cv), .cmd_take(ct), .cmd_out(cq));

  vrtwc_exec #(.ENTRIES(ENTRIES)) u_exec (.clk, .rst_n, .phys_addr_bits(pab_r),
    .entries_in_use(eiu_r), .cmd_valid(cv), .cmd_take(ct), .cmd(cq),
    .res_valid(rv), .res_ready(out_pop), .res(rs));

  assign out_empty     = !rv;
  assign out_kind      = rs.kind;
  assign out_out_index = rs.idx;
  assign out_out_base  = rs.base;
  assign out_out_mask  = rs.mask;
  assign out_last      = rs.last;

endmodule

// ----- sim/variable_range_table_wc_mapper_tb.sv -----
module variable_range_table_wc_mapper_tb;

  localparam int NumEntries = 8;
  localparam int CycleLimit = 1000000;
  localparam int SettleCycles = 100;
  localparam logic CfgAddrBits = 1'b0;
  localparam logic CfgEntries = 1'b1;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [5:0]  cfg_wdata;
  logic        in_push;
  logic        in_full;
  logic [1:0]  in_opcode;
  logic [2:0]  in_entry_index;
  logic [63:0] in_base_word;
  logic [63:0] in_mask_word;
  logic [51:0] in_region_addr;
  logic [52:0] in_region_size;
  logic        out_empty;
  logic        out_pop;
  logic [2:0]  out_kind;
  logic [2:0]  out_out_index;
  logic [63:0] out_out_base;
  logic [63:0] out_out_mask;
  logic        out_last;

  variable_range_table_wc_mapper #(.ENTRIES(NumEntries)) i_dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_push, .in_full, .in_opcode, .in_entry_index, .in_base_word, .in_mask_word,
    .in_region_addr, .in_region_size,
    .out_empty, .out_pop, .out_kind, .out_out_index, .out_out_base, .out_out_mask,
    .out_last
  );

  // Shadow copy of the range table and its two registers.
  logic [63:0] shadow_base [NumEntries];
  logic [63:0] shadow_mask [NumEntries];
  logic [5:0]  shadow_addr_bits;
  logic [3:0]  shadow_entries;
  int          words_this_op;

  vrtwc_pkg::res_t expected_words [$];
  int   mismatches;
  int   cycles;
  int   send_idle;
  int   recv_stall;

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("variable_range_table_wc_mapper_tb: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_pop <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    vrtwc_pkg::res_t want;
    if (rst_n && !out_empty && out_pop) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: kind %0d index %0d base %h mask %h last %0d",
                   out_kind, out_out_index, out_out_base, out_out_mask, out_last);
      end else begin
        want = expected_words.pop_front();
        if (out_kind !== want.kind || out_out_index !== want.idx ||
            out_out_base !== want.base || out_out_mask !== want.mask ||
            out_last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected kind %0d index %0d base %h mask %h last %0d",
                     want.kind, want.idx, want.base, want.mask, want.last);
            $display("          actual   kind %0d index %0d base %h mask %h last %0d",
                     out_kind, out_out_index, out_out_base, out_out_mask, out_last);
          end
        end
      end
    end
  end

  function automatic logic [63:0] addr_mask();
    int w;
    w = shadow_addr_bits;
    if (w < 36) w = 36;
    if (w > 52) w = 52;
    return (64'd1 << w) - 64'd1;
  endfunction

  function automatic int active_entries();
    return (shadow_entries > NumEntries) ? NumEntries : int'(shadow_entries);
  endfunction

  function automatic int first_free();
    for (int i = 0; i < active_entries(); i++)
      if (!shadow_mask[i][11]) return i;
    return -1;
  endfunction

  function automatic logic [63:0] fit_chunk(logic [63:0] b, logic [63:0] sz);
    logic [63:0] p;
    p = 64'd1;
    while (p <= (sz >> 1)) p = p << 1;
    while ((b & (p - 64'd1)) != 0) p = p >> 1;
    return p;
  endfunction

  task automatic expect_word(vrtwc_pkg::kind_t k, int idx, logic [63:0] b, logic [63:0] m,
                             bit fin);
    vrtwc_pkg::res_t w;
    // Nine non-final words at most, so the status always fits.
    if (words_this_op >= (fin ? vrtwc_pkg::MaxResults : vrtwc_pkg::MaxResults - 1)) return;
    w.kind = k;
    w.idx = idx[2:0];
    w.base = b;
    w.mask = m;
    w.last = fin;
    expected_words.push_back(w);
    words_this_op++;
  endtask

  task automatic program_entry(int i, logic [63:0] b, logic [63:0] sz, logic [63:0] ty);
    logic [63:0] pm;
    pm = addr_mask();
    shadow_mask[i] = 64'd0;
    if (sz != 0) begin
      shadow_base[i] = (b & pm & ~vrtwc_pkg::PageLow) | ty;
      shadow_mask[i] = (~(sz - 64'd1) & pm) | vrtwc_pkg::ValidBit;
    end
    expect_word(vrtwc_pkg::KIND_WRITTEN, i, shadow_base[i], shadow_mask[i], 1'b0);
  endtask

  task automatic cover_span(logic [63:0] b, logic [63:0] sz, logic [63:0] ty);
    logic [63:0] c;
    int k;
    while (sz > 0) begin
      c = fit_chunk(b, sz);
      k = first_free();
      if (k < 0) break;
      program_entry(k, b, c, ty);
      b += c;
      sz -= c;
    end
  endtask

  task automatic predict_map(logic [63:0] addr, logic [63:0] req);
    logic [63:0] sz, fb, fe, ob, os, oe, ot, pm;
    int k;
    if (req == 0) begin
      expect_word(vrtwc_pkg::KIND_BADSIZE, 0, 64'd0, 64'd0, 1'b1);
      return;
    end
    sz = 64'd1;
    while (sz < req) sz = sz << 1;
    fb = addr & ~(sz - 64'd1);
    fe = fb + sz;
    pm = addr_mask();
    for (int i = 0; i < active_entries(); i++) begin
      if (!shadow_mask[i][11]) continue;
      ot = shadow_base[i] & vrtwc_pkg::TypeMask;
      ob = shadow_base[i] & pm & ~vrtwc_pkg::PageLow;
      os = (~(shadow_mask[i] & pm & ~vrtwc_pkg::PageLow) & pm) + 64'd1;
      oe = ob + os;
      if (fb < oe && fe > ob) begin
        program_entry(i, 64'd0, 64'd0, 64'd0);
        if (fb > ob) cover_span(ob, fb - ob, ot);
        if (oe > fe) cover_span(fe, oe - fe, ot);
        break;
      end
    end
    k = first_free();
    if (k < 0) begin
      expect_word(vrtwc_pkg::KIND_NOFREE, 0, 64'd0, 64'd0, 1'b1);
      return;
    end
    program_entry(k, fb, sz, {56'd0, vrtwc_pkg::TypeWc});
    expect_word(vrtwc_pkg::KIND_MAPPED, k, shadow_base[k], shadow_mask[k], 1'b1);
  endtask

  task automatic predict_op(logic [1:0] op, logic [2:0] idx, logic [63:0] b,
                            logic [63:0] m, logic [51:0] addr, logic [52:0] size);
    words_this_op = 0;
    case (op)
      vrtwc_pkg::OP_LOAD: begin
        shadow_base[idx] = b;
        shadow_mask[idx] = m;
        expect_word(vrtwc_pkg::KIND_WRITTEN, idx, b, m, 1'b1);
      end
      vrtwc_pkg::OP_READ:
        expect_word(vrtwc_pkg::KIND_READ, idx, shadow_base[idx], shadow_mask[idx], 1'b1);
      vrtwc_pkg::OP_MAP: predict_map({12'd0, addr}, {11'd0, size});
      default: ;
    endcase
  endtask

  task automatic send_word(logic [1:0] op, logic [2:0] idx, logic [63:0] b,
                           logic [63:0] m, logic [51:0] addr, logic [52:0] size);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_opcode <= op;
    in_entry_index <= idx;
    in_base_word <= b;
    in_mask_word <= m;
    in_region_addr <= addr;
    in_region_size <= size;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    predict_op(op, idx, b, m, addr, size);
  endtask

  // Holds the sender until every expected word is back, then lets the
  // block finish any work that produces no word.
  task automatic wait_idle();
    @(negedge clk);
    in_push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [5:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == CfgAddrBits) shadow_addr_bits = value;
    else shadow_entries = value[3:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] range_mask_for(logic [63:0] sz);
    return (~(sz - 64'd1) & addr_mask()) | vrtwc_pkg::ValidBit;
  endfunction

  task automatic send_load(int idx, logic [63:0] b, logic [63:0] m);
    send_word(vrtwc_pkg::OP_LOAD, idx[2:0], b, m, 52'(rand64()), 53'(rand64()));
  endtask

  task automatic send_map(logic [51:0] addr, logic [52:0] size);
    send_word(vrtwc_pkg::OP_MAP, 3'($urandom_range(7)), rand64(), rand64(), addr, size);
  endtask

  task automatic test_load_read();
    for (int i = 0; i < NumEntries; i++)
      send_load(i, rand64(), rand64() & ~vrtwc_pkg::ValidBit);
    send_load(0, '1, '1);
    send_word(vrtwc_pkg::OP_READ, 3'd0, '0, '0, '0, '0);
    send_load(7, '0, '0);
    send_word(vrtwc_pkg::OP_READ, 3'd7, '1, '1, '1, '1);
    send_word(vrtwc_pkg::OP_NONE, 3'd2, rand64(), rand64(), 52'(rand64()), 53'(rand64()));
    send_load(0, 64'd0, 64'd0);
  endtask

  task automatic test_map_cases();
    // A write-back megabyte split by a small region leaves a head and a tail.
    send_load(0, 64'h10_0006, range_mask_for(64'h10_0000));
    send_map(52'h14_0000, 53'h1_0000);
    wait_idle();
    send_map(52'h0, 53'd0);
    send_map(52'h2_3457, 53'd3);
    send_map('1, {1'b1, 52'd0});
    send_map(52'h0, 53'd1);
    // With every entry valid, each region overlaps one entry, which it clears and reuses.
    for (int i = 0; i < NumEntries; i++)
      send_load(i, 64'h1_0000_0000 * 64'(i + 1) | 64'd6, range_mask_for(64'h1000));
    send_map(52'h8_0000_0000, 53'h1000);
    send_map(52'h1_0000_0000, 53'h1000);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    write_reg(CfgEntries, 6'd0);
    send_map(52'h5000, 53'h2000);
    write_reg(CfgEntries, 6'd15);
    write_reg(CfgAddrBits, 6'd0);
    send_load(1, 64'hFFFF_FFFF_FFFF_F005, 64'hFFFF_FFFF_FFF0_0800);
    send_map(52'hF_FFFF_F000, 53'h4000);
    write_reg(CfgAddrBits, 6'd63);
    send_load(2, 64'h000F_FFF0_0000_0004, 64'hFFFF_FFFF_FFFF_F800);
    send_map(52'hF_FFF0_0000_1000, 53'h1000);
    send_word(vrtwc_pkg::OP_READ, 3'd2, '0, '0, '0, '0);
    write_reg(CfgAddrBits, 6'd36);
    write_reg(CfgEntries, 6'd8);
  endtask

  task automatic random_word();
    int r, k;
    logic [63:0] sz;
    r = $urandom_range(99);
    if (r < 45) begin
      k = $urandom_range(12, 22);
      sz = 64'($urandom_range(1, 1 << k));
      send_map(52'($urandom_range(0, (1 << 24) - 1)), sz[52:0]);
    end else if (r < 55) begin
      case ($urandom_range(3))
        0: send_map(52'(rand64()), 53'd0);
        1: send_map(52'(rand64()), {1'b1, 52'd0});
        default: send_map(52'(rand64()), 53'(rand64() & 64'hF_FFFF_FFFF_FFFF));
      endcase
    end else if (r < 70) begin
      sz = 64'd1 << $urandom_range(12, 22);
      send_load(int'($urandom_range(7)),
                (64'($urandom_range(0, (1 << 24) - 1)) & ~(sz - 64'd1)) |
                64'($urandom_range(0, 6)),
                range_mask_for(sz));
    end else if (r < 82) begin
      send_load(int'($urandom_range(7)), rand64(), rand64() & ~vrtwc_pkg::ValidBit);
    end else if (r < 88) begin
      send_load(int'($urandom_range(7)), rand64(), rand64());
    end else if (r < 97) begin
      send_word(vrtwc_pkg::OP_READ, 3'($urandom_range(7)), rand64(), rand64(),
                52'(rand64()), 53'(rand64()));
    end else begin
      send_word(vrtwc_pkg::OP_NONE, 3'($urandom_range(7)), rand64(), rand64(),
                52'(rand64()), 53'(rand64()));
    end
  endtask

  task automatic test_random(int idle, int stall, logic [5:0] bits, logic [5:0] count);
    write_reg(CfgAddrBits, bits);
    write_reg(CfgEntries, count);
    send_idle = idle;
    recv_stall = stall;
    repeat (60) random_word();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_wdata = '0;
    in_push = 1'b0;
    in_opcode = vrtwc_pkg::OP_NONE;
    in_entry_index = '0;
    in_base_word = '0;
    in_mask_word = '0;
    in_region_addr = '0;
    in_region_size = '0;
    out_pop = 1'b0;
    mismatches = 0;
    cycles = 0;
    send_idle = 0;
    recv_stall = 0;
    shadow_addr_bits = 6'd36;
    shadow_entries = 4'd8;
    for (int i = 0; i < NumEntries; i++) begin
      shadow_base[i] = '0;
      shadow_mask[i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_load_read();
    test_map_cases();
    test_config_extremes();
    test_random(0, 0, 6'd36, 6'd8);
    test_random(84, 0, 6'd52, 6'd4);
    test_random(0, 84, 6'd44, 6'd8);
    test_random(33, 33, 6'd40, 6'd15);
    wait_idle();

    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("variable_range_table_wc_mapper_tb: clean");
    end else begin
      $display("variable_range_table_wc_mapper_tb: errors");
    end
    $finish;
  end

endmodule
